>>> rtl/core/mrlp_pkg.sv
`default_nettype none

package mrlp_pkg;

  localparam int TAIL_LEN = 9;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // newest byte at index 0, oldest at the top
  typedef logic [TAIL_LEN-1:0][7:0] tail_t;

  // packed so that the first character of each pattern is the oldest byte
  localparam logic [5:0][7:0] PAT_RING = {"R", "I", "N", "G", CH_CR, CH_LF};
  localparam logic [4:0][7:0] PAT_RDY  = {"R", "D", "Y", CH_CR, CH_LF};
  localparam logic [5:0][7:0] PAT_OK   = {CH_CR, CH_LF, "O", "K", CH_CR, CH_LF};
  localparam logic [8:0][7:0] PAT_ERR  =
    {CH_CR, CH_LF, "E", "R", "R", "O", "R", CH_CR, CH_LF};

  typedef struct packed {
    logic ring;
    logic rdy;
    logic ok;
    logic err;
  } match_t;

  function automatic logic is_crlf(input logic [7:0] b);
    return (b == CH_CR) || (b == CH_LF);
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/mrlp_if.sv
`default_nettype none

interface mrlp_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source(output valid, output req_type, output rx_byte, output read_index,
                 input ready);
  modport sink(input valid, input req_type, input rx_byte, input read_index,
               output ready);
endinterface

interface mrlp_rsp_if;
  logic       valid;
  logic       ready;
  logic       ok_seen;
  logic       error_seen;
  logic       ring_seen;
  logic       ready_seen;
  logic [8:0] payload_length;
  logic [7:0] read_byte;

  modport source(output valid, output ok_seen, output error_seen, output ring_seen,
                 output ready_seen, output payload_length, output read_byte,
                 input ready);
  modport sink(input valid, input ok_seen, input error_seen, input ring_seen,
               input ready_seen, input payload_length, input read_byte,
               output ready);
endinterface

`default_nettype wire

>>> rtl/core/modem_response_line_parser.sv
`default_nettype none

// Channel  Dir  Fields                                    Accept
// req_ch   in   req_type, rx_byte, read_index             valid & ready
// rsp_ch   out  ok_seen, error_seen, ring_seen,            valid & ready
//               ready_seen, payload_length, read_byte
//
// One word in, one word out, one word per cycle sustained unless stalled. The
// line store is a single-port-write / single-read synchronous RAM; a push
// writes at the fill pointer, a read registers the RAM output in the RAM read
// stage, then in the output register. A stalled output still lets one more word
// in. Reset clears counters, tail bytes and flags; the RAM needs no clearing.

module modem_response_line_parser #(
  parameter int STORE_DEPTH = 256
) (
  input  wire              clk,
  input  wire              rst,
  mrlp_req_if.sink         req_ch,
  mrlp_rsp_if.source       rsp_ch
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int LW = (CW > 9) ? CW : 9;
  localparam int IW = (AW > 8) ? AW : 8;

  // line state
  logic [CW-1:0]     fill, fill_next;
  logic [CW-1:0]     cont_len, cont_len_next;
  logic [CW-1:0]     run_base, run_base_next;
  logic [CW-1:0]     vis, vis_next;
  mrlp_pkg::tail_t   tail, tail_next;
  logic              ok_flag, ok_flag_next;
  logic              err_flag, err_flag_next;
  logic              ring_flag, ring_flag_next;
  logic              rdy_flag, rdy_flag_next;

  logic [7:0]        line_mem [STORE_DEPTH];
  logic [7:0]        rd_data;

  // RAM read stage
  logic              s1_valid;
  logic              s1_ok, s1_err, s1_ring, s1_rdy, s1_hit;
  logic [8:0]        s1_plen;

  // output register
  logic              s2_valid;
  logic              s2_ok, s2_err, s2_ring, s2_rdy;
  logic [8:0]        s2_plen;
  logic [7:0]        s2_byte;

  logic              s1_move, accept, push, rd_req;
  logic              clr, b_crlf, drop;
  logic [7:0]        b;
  logic [CW-1:0]     f0, f1, cl0, rb0, cl1, rb1;
  mrlp_pkg::tail_t   t0, t1;
  mrlp_pkg::match_t  hit;
  logic              ring_hit, rdy_hit, ok_hit, err_hit;
  logic [LW-1:0]     vis_w, idx_w;
  logic [IW-1:0]     idx_a;
  logic [AW-1:0]     raddr;
  logic [8:0]        plen_next;
  logic              rd_hit;

  assign s1_move      = s1_valid && (!s2_valid || rsp_ch.ready);
  assign req_ch.ready = !rst && (!s1_valid || s1_move);
  assign accept       = req_ch.valid && req_ch.ready;
  assign push         = accept && (req_ch.req_type == mrlp_pkg::REQ_PUSH);
  assign rd_req       = accept && (req_ch.req_type == mrlp_pkg::REQ_READ);
  assign b            = req_ch.rx_byte;

  // pending final code or full store empties the line before the new byte
  assign clr    = ok_flag || err_flag || (fill == CW'(STORE_DEPTH));
  assign f0     = clr ? '0 : fill;
  assign cl0    = clr ? '0 : cont_len;
  assign rb0    = clr ? '0 : run_base;
  assign t0     = clr ? '0 : tail;
  assign b_crlf = mrlp_pkg::is_crlf(b);
  assign drop   = (f0 == '0) && b_crlf;
  assign f1     = f0 + CW'(1);
  assign t1     = {t0[mrlp_pkg::TAIL_LEN-2:0], b};

  // a new text run starts after a CR/LF or at the line start
  assign rb1 = (!b_crlf && ((f0 == '0) || mrlp_pkg::is_crlf(t0[0]))) ? cl0 : rb0;
  assign cl1 = b_crlf ? cl0 : f1;

  mrlp_tail_match u_match (
    .win (t1),
    .hit (hit)
  );

  assign ring_hit = hit.ring && (f1 == CW'(6));
  assign rdy_hit  = hit.rdy  && (f1 == CW'(5));
  assign ok_hit   = hit.ok   && (f1 >= CW'(6));
  assign err_hit  = hit.err  && (f1 >= CW'(9));

  always_comb begin
    fill_next      = fill;
    cont_len_next  = cont_len;
    run_base_next  = run_base;
    vis_next       = vis;
    tail_next      = tail;
    ok_flag_next   = ok_flag;
    err_flag_next  = err_flag;
    ring_flag_next = ring_flag;
    rdy_flag_next  = rdy_flag;
    if (push) begin
      fill_next     = f0;
      cont_len_next = cl0;
      run_base_next = rb0;
      vis_next      = clr ? '0 : vis;
      tail_next     = t0;
      ok_flag_next  = 1'b0;
      err_flag_next = 1'b0;
      if (!drop) begin
        if (ring_hit || rdy_hit) begin
          ring_flag_next = ring_flag || ring_hit;
          rdy_flag_next  = rdy_flag || rdy_hit;
          fill_next      = '0;
          cont_len_next  = '0;
          run_base_next  = '0;
          vis_next       = '0;
          tail_next      = '0;
        end else begin
          fill_next     = f1;
          cont_len_next = cl1;
          run_base_next = rb1;
          tail_next     = t1;
          vis_next      = f1;
          if (ok_hit || err_hit) begin
            ok_flag_next  = ok_hit;
            err_flag_next = err_hit;
            vis_next      = rb1;
          end
        end
      end
    end
  end

  assign vis_w     = LW'(vis_next);
  assign plen_next = (vis_w > LW'(511)) ? 9'h1FF : vis_w[8:0];
  assign idx_w     = LW'(req_ch.read_index);
  assign idx_a     = IW'(req_ch.read_index);
  assign raddr     = idx_a[AW-1:0];
  assign rd_hit    = (req_ch.req_type == mrlp_pkg::REQ_READ) && (idx_w < vis_w);

  always_ff @(posedge clk) begin
    if (push && !drop) begin
      line_mem[f0[AW-1:0]] <= b;
    end
    if (rd_req) begin
      rd_data <= line_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      cont_len  <= '0;
      run_base  <= '0;
      vis       <= '0;
      tail      <= '0;
      ok_flag   <= 1'b0;
      err_flag  <= 1'b0;
      ring_flag <= 1'b0;
      rdy_flag  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
    end else begin
      fill      <= fill_next;
      cont_len  <= cont_len_next;
      run_base  <= run_base_next;
      vis       <= vis_next;
      tail      <= tail_next;
      ok_flag   <= ok_flag_next;
      err_flag  <= err_flag_next;
      ring_flag <= ring_flag_next;
      rdy_flag  <= rdy_flag_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (rsp_ch.ready) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok   <= ok_flag_next;
      s1_err  <= err_flag_next;
      s1_ring <= ring_flag_next;
      s1_rdy  <= rdy_flag_next;
      s1_plen <= plen_next;
      s1_hit  <= rd_hit;
    end
    if (s1_move) begin
      s2_ok   <= s1_ok;
      s2_err  <= s1_err;
      s2_ring <= s1_ring;
      s2_rdy  <= s1_rdy;
      s2_plen <= s1_plen;
      s2_byte <= s1_hit ? rd_data : 8'h00;
    end
  end

  assign rsp_ch.valid          = s2_valid;
  assign rsp_ch.ok_seen        = s2_ok;
  assign rsp_ch.error_seen     = s2_err;
  assign rsp_ch.ring_seen      = s2_ring;
  assign rsp_ch.ready_seen     = s2_rdy;
  assign rsp_ch.payload_length = s2_plen;
  assign rsp_ch.read_byte      = s2_byte;

endmodule

`default_nettype wire

>>> rtl/core/mrlp_tail_match.sv
`default_nettype none

module mrlp_tail_match (
  input  wire mrlp_pkg::tail_t  win,
  output mrlp_pkg::match_t      hit
);

  always_comb begin
    hit.ring = (win[5:0] == mrlp_pkg::PAT_RING);
    hit.rdy  = (win[4:0] == mrlp_pkg::PAT_RDY);
    hit.ok   = (win[5:0] == mrlp_pkg::PAT_OK);
    hit.err  = (win[8:0] == mrlp_pkg::PAT_ERR);
  end

endmodule

`default_nettype wire
